// ===== rtl/core/button_debounce_long_press_repeat_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH

// cond must hold at every edge out of reset
`define BDLP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("%m: invariant violated");

// pre at one edge implies post at the next edge
`define BDLP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("%m: sequence violated");

`endif

// ===== rtl/core/bdlp_pkg.sv =====
package bdlp_pkg;

    localparam int BUTTON_COUNT_DEF = 9;
    localparam int FIELD_W          = 9;   // width of every button vector field
    localparam int TIME_W           = 32;
    localparam int CFG_W            = 16;
    localparam int ADDR_W           = 4;
    localparam int APB_DATA_W       = 32;

    // input tdata layout
    localparam int IN_NOW_LSB   = 0;
    localparam int IN_PIN_LSB   = IN_NOW_LSB + TIME_W;
    localparam int IN_TDATA_W   = 48;

    // command codes carried in tuser
    localparam logic CMD_SCAN   = 1'b0;
    localparam logic CMD_IGNORE = 1'b1;

    // register index, paddr[3:2]
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_REPEAT     = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_press_time;
        logic [CFG_W-1:0] repeat_interval;
    } lane_cfg_t;

    typedef struct packed {
        logic click;
        logic rpt;
        logic stable;
        logic long_held;
    } lane_out_t;

    // packed result, click_pulses in the lowest bits
    typedef struct packed {
        logic [FIELD_W-1:0] long_held;
        logic [FIELD_W-1:0] stable_pressed;
        logic [FIELD_W-1:0] repeat_pulses;
        logic [FIELD_W-1:0] click_pulses;
    } result_t;

    localparam int RESULT_W    = $bits(result_t);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/core/bdlp_lane.sv =====
module bdlp_lane
    import bdlp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              cmd_ignore,
    input  logic [TIME_W-1:0] now_ms,
    input  logic              pin_down,
    input  lane_cfg_t         cfg,
    output lane_out_t         res
);

    logic              last_raw_reg,     last_raw_next;
    logic              stable_reg,       stable_next;
    logic              long_reg,         long_next;
    logic              ignore_reg,       ignore_next;
    logic [TIME_W-1:0] change_stamp_reg, change_stamp_next;
    logic [TIME_W-1:0] press_stamp_reg,  press_stamp_next;
    logic [TIME_W-1:0] repeat_stamp_reg, repeat_stamp_next;

    logic [TIME_W-1:0] change_age, press_age, press_age_n, repeat_age;
    logic              settled, press_edge, long_ok;

    // all three ages computed side by side, wrap mod 2^32
    assign change_age = now_ms - change_stamp_reg;
    assign press_age  = now_ms - press_stamp_reg;
    assign repeat_age = now_ms - repeat_stamp_reg;
    assign settled    = change_age >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time};

    always_comb begin
        last_raw_next     = last_raw_reg;
        stable_next       = stable_reg;
        long_next         = long_reg;
        ignore_next       = ignore_reg;
        change_stamp_next = change_stamp_reg;
        press_stamp_next  = press_stamp_reg;
        repeat_stamp_next = repeat_stamp_reg;
        press_edge        = 1'b0;
        press_age_n       = press_age;
        long_ok           = 1'b0;
        res               = '0;

        if (cmd_ignore) begin
            if (stable_reg) begin
                ignore_next = 1'b1;
            end
            res.stable    = stable_reg;
            res.long_held = long_reg;
        end else begin
            if (pin_down != last_raw_reg) begin
                change_stamp_next = now_ms;
                last_raw_next     = pin_down;
            end else if (settled && (pin_down != stable_reg)) begin
                stable_next = pin_down;
                long_next   = 1'b0;
                if (pin_down) begin
                    press_edge       = 1'b1;
                    res.click        = !ignore_reg;
                    press_stamp_next = now_ms;
                end else begin
                    press_stamp_next = '0;
                    ignore_next      = 1'b0;
                end
            end

            // fresh press has age zero
            if (press_edge) begin
                press_age_n = '0;
            end
            long_ok = stable_next && (press_stamp_next != '0) && !ignore_next &&
                      (press_age_n >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_time});
            if (long_ok) begin
                long_next = 1'b1;
                if (repeat_age >= {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_interval}) begin
                    res.rpt           = 1'b1;
                    repeat_stamp_next = now_ms;
                end
            end
            res.stable    = stable_next;
            res.long_held = long_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg     <= 1'b0;
            stable_reg       <= 1'b0;
            long_reg         <= 1'b0;
            ignore_reg       <= 1'b0;
            change_stamp_reg <= '0;
            press_stamp_reg  <= '0;
            repeat_stamp_reg <= '0;
        end else if (en) begin
            last_raw_reg     <= last_raw_next;
            stable_reg       <= stable_next;
            long_reg         <= long_next;
            ignore_reg       <= ignore_next;
            change_stamp_reg <= change_stamp_next;
            press_stamp_reg  <= press_stamp_next;
            repeat_stamp_reg <= repeat_stamp_next;
        end
    end

endmodule

// ===== rtl/core/bdlp_merge.sv =====
module bdlp_merge
    import bdlp_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_accept,
    output logic                   in_ready,
    input  lane_out_t              lanes [BUTTON_COUNT],
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [FIELD_W-1:0] click_v, rpt_v, stable_v, long_v;
    result_t            merged;
    result_t            out_data_reg,  out_data_next;
    result_t            skid_data_reg, skid_data_next;
    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;

    // lanes past the field width are dropped, missing lanes read zero
    for (genvar j = 0; j < FIELD_W; j++) begin : g_pack
        if (j < BUTTON_COUNT) begin : g_lane
            assign click_v[j]  = lanes[j].click;
            assign rpt_v[j]    = lanes[j].rpt;
            assign stable_v[j] = lanes[j].stable;
            assign long_v[j]   = lanes[j].long_held;
        end else begin : g_none
            assign click_v[j]  = 1'b0;
            assign rpt_v[j]    = 1'b0;
            assign stable_v[j] = 1'b0;
            assign long_v[j]   = 1'b0;
        end
    end

    assign merged.click_pulses   = click_v;
    assign merged.repeat_pulses  = rpt_v;
    assign merged.stable_pressed = stable_v;
    assign merged.long_held      = long_v;

    // two-entry output buffer: ready depends only on skid occupancy
    assign in_ready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_data_reg};

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = skid_valid_reg;
            out_data_next  = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (in_accept) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_next = 1'b1;
                out_data_next  = merged;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = merged;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/core/button_debounce_long_press_repeat.sv =====
// Channel  Dir  Handshake          Payload (low bit first)
// s_       in   s_tvalid/s_tready  tdata: now_ms[31:0], pin_levels[40:32]; tuser: cmd
// m_       out  m_tvalid/m_tready  tdata: click, repeat, stable, long_held (9 bits each)
// apb      in   psel/penable/pready 0x0 debounce, 0x4 long press, 0x8 repeat interval
//
// One scan per cycle sustained while the sink takes results; each result is registered in the output buffer.
// Throughput is set by the per-button lane: its wrap-around age compares are
// combinational, so lane state is ready for the next request at once.
// A two-entry output buffer decouples sides: s_tready drops only when both
// entries hold results that the sink has not taken.
// Reset (aresetn low, synchronous) clears all button state and loads the
// default register values; no clearing pass is needed.
module button_debounce_long_press_repeat
    import bdlp_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // scan request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // now_ms[31:0], pin_levels[40:32], zero pad
    input  logic                   s_tuser,   // cmd
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // click[8:0], repeat[17:9],
                                              // stable[26:18], long_held[35:27], zero pad
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    lane_cfg_t         cfg_reg, cfg_next;
    logic              cfg_write;
    logic [1:0]        reg_index;
    logic              s_accept;
    logic              cmd_ignore;
    logic [TIME_W-1:0] now_ms;
    logic [BUTTON_COUNT-1:0] pin_down;
    lane_out_t         lane_res [BUTTON_COUNT];

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (reg_index)
                REG_DEBOUNCE:   cfg_next.debounce_time   = pwdata[CFG_W-1:0];
                REG_LONG_PRESS: cfg_next.long_press_time = pwdata[CFG_W-1:0];
                REG_REPEAT:     cfg_next.repeat_interval = pwdata[CFG_W-1:0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_DEBOUNCE:   prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_reg.debounce_time};
            REG_LONG_PRESS: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_reg.long_press_time};
            REG_REPEAT:     prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_reg.repeat_interval};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time   <= CFG_W'(20);
            cfg_reg.long_press_time <= CFG_W'(500);
            cfg_reg.repeat_interval <= CFG_W'(100);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- request decode ----------------
    assign s_accept   = s_tvalid && s_tready;
    assign cmd_ignore = (s_tuser == CMD_IGNORE);
    assign now_ms     = s_tdata[IN_NOW_LSB +: TIME_W];

    // pins are active low; buttons past the pin field read as pressed
    for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
        if (i < FIELD_W) begin : g_pin
            assign pin_down[i] = !s_tdata[IN_PIN_LSB + i];
        end else begin : g_nopin
            assign pin_down[i] = 1'b1;
        end

        bdlp_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (s_accept),
            .cmd_ignore  (cmd_ignore),
            .now_ms      (now_ms),
            .pin_down    (pin_down[i]),
            .cfg         (cfg_reg),
            .res         (lane_res[i])
        );
    end

    // ---------------- merge and output buffer ----------------
    bdlp_merge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .in_ready  (s_tready),
        .lanes     (lane_res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/core/bdlp_checker.sv =====
`include "button_debounce_long_press_repeat_defines.svh"

module bdlp_checker
    import bdlp_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    result_t res;
    assign res = m_tdata[RESULT_W-1:0];

    // stalled result stays put
    `BDLP_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `BDLP_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
    // a click only comes with the button now stably pressed
    `BDLP_ASSERT_ALWAYS(a_click_pressed,
        !m_tvalid || ((res.click_pulses & ~res.stable_pressed) == '0))
    // repeats only while long-held
    `BDLP_ASSERT_ALWAYS(a_repeat_long,
        !m_tvalid || ((res.repeat_pulses & ~res.long_held) == '0))

endmodule

bind button_debounce_long_press_repeat bdlp_checker u_bdlp_checker (.*);
